>>> rtl/core/rle_pkg.sv
package rle_pkg;

  // Count fields in the command word cover the full range of both limits.
  localparam int CNT_W = 7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_result;
    logic       stream_done;
  } out_item_t;

  // One command per input item that produces output: an optional run pair and
  // an optional literal group, in the order given by lit_first.
  typedef struct packed {
    logic             run_en;
    logic [CNT_W-1:0] run_cnt;
    logic [7:0]       run_sym;
    logic             lit_en;
    logic [CNT_W-1:0] lit_cnt;
    logic             lit_bank;
    logic             lit_first;
    logic             done;
  } cmd_t;

  // Back end hands a literal bank back to the front end.
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

endpackage

>>> rtl/core/rle_ram.sv
module rle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/rle_front.sv
module rle_front #(
  parameter int MAX_RUN     = 127,
  parameter int MAX_LITERAL = 63,
  localparam int AW         = $clog2(MAX_LITERAL)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rle_pkg::in_item_t in_data,
  input  logic              fifo_full,
  output logic              push,
  output rle_pkg::cmd_t     cmd,
  output logic              wr_en,
  output logic [AW:0]       wr_addr,
  output logic [7:0]        wr_data,
  input  rle_pkg::bank_rel_t rel
);
  import rle_pkg::*;

  localparam int CW = $clog2(MAX_LITERAL + 1);
  localparam int RW = $clog2(MAX_RUN + 1);
  localparam logic [CW-1:0] LIT_MAX = CW'(MAX_LITERAL);
  localparam logic [RW-1:0] RUN_MAX = RW'(MAX_RUN);
  localparam logic [RW-1:0] RUN_TWO = RW'(2);

  logic [7:0]    prev_r, prev_nxt;
  logic          have_r, have_nxt;
  logic          in_run_r, in_run_nxt;
  logic [RW-1:0] run_cnt_r, run_cnt_nxt;
  logic [CW-1:0] lit_cnt_r, lit_cnt_nxt;
  logic          wbank_r, wbank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic          acc;
  logic          same;
  logic [CW-1:0] lc_inc, lc_dec;
  logic [RW-1:0] rc_inc;

  // Hold input while the queue is full or the bank to be filled is still draining.
  assign in_stall = fifo_full || busy_r[wbank_r];
  assign acc      = in_valid && !in_stall;
  assign same     = have_r && (in_data.in_byte == prev_r);
  assign lc_inc   = CW'(lit_cnt_r + 1'b1);
  assign lc_dec   = CW'(lit_cnt_r - 1'b1);
  assign rc_inc   = RW'(run_cnt_r + 1'b1);
  assign wr_data  = in_data.in_byte;
  assign wr_addr  = {wbank_r, lit_cnt_r[AW-1:0]};

  always_comb begin
    prev_nxt    = prev_r;
    have_nxt    = have_r;
    in_run_nxt  = in_run_r;
    run_cnt_nxt = run_cnt_r;
    lit_cnt_nxt = lit_cnt_r;
    wbank_nxt   = wbank_r;
    busy_nxt    = busy_r;
    cmd         = '0;
    wr_en       = 1'b0;
    push        = 1'b0;
    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (acc) begin
      if (same && in_run_r) begin
        if (rc_inc == RUN_MAX) begin
          cmd.run_en  = 1'b1;
          cmd.run_cnt = CNT_W'(rc_inc);
          cmd.run_sym = prev_r;
          in_run_nxt  = 1'b0;
          run_cnt_nxt = '0;
          have_nxt    = 1'b0;
        end else begin
          run_cnt_nxt = rc_inc;
        end
      end else if (same) begin
        // Take the repeated byte back out of the group and open a run of two.
        cmd.lit_first = 1'b1;
        if (lc_dec != '0) begin
          cmd.lit_en  = 1'b1;
          cmd.lit_cnt = CNT_W'(lc_dec);
        end
        lit_cnt_nxt = '0;
        in_run_nxt  = 1'b1;
        run_cnt_nxt = RUN_TWO;
        if (RUN_TWO == RUN_MAX) begin
          cmd.run_en  = 1'b1;
          cmd.run_cnt = CNT_W'(RUN_TWO);
          cmd.run_sym = prev_r;
          in_run_nxt  = 1'b0;
          run_cnt_nxt = '0;
          have_nxt    = 1'b0;
        end
      end else begin
        if (in_run_r) begin
          cmd.run_en  = 1'b1;
          cmd.run_cnt = CNT_W'(run_cnt_r);
          cmd.run_sym = prev_r;
          in_run_nxt  = 1'b0;
          run_cnt_nxt = '0;
        end
        wr_en    = 1'b1;
        prev_nxt = in_data.in_byte;
        have_nxt = 1'b1;
        if (lc_inc == LIT_MAX) begin
          cmd.lit_en  = 1'b1;
          cmd.lit_cnt = CNT_W'(lc_inc);
          lit_cnt_nxt = '0;
          have_nxt    = 1'b0;
        end else begin
          lit_cnt_nxt = lc_inc;
        end
      end
      if (in_data.end_of_stream) begin
        if (in_run_nxt) begin
          cmd.run_en  = 1'b1;
          cmd.run_cnt = CNT_W'(run_cnt_nxt);
          cmd.run_sym = prev_nxt;
        end else if (lit_cnt_nxt != '0) begin
          cmd.lit_en  = 1'b1;
          cmd.lit_cnt = CNT_W'(lit_cnt_nxt);
        end
        prev_nxt    = '0;
        have_nxt    = 1'b0;
        in_run_nxt  = 1'b0;
        run_cnt_nxt = '0;
        lit_cnt_nxt = '0;
      end
      cmd.lit_bank = wbank_r;
      cmd.done     = in_data.end_of_stream;
      push         = cmd.run_en || cmd.lit_en;
      if (cmd.lit_en) begin
        wbank_nxt         = ~wbank_r;
        busy_nxt[wbank_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      have_r    <= 1'b0;
      in_run_r  <= 1'b0;
      run_cnt_r <= '0;
      lit_cnt_r <= '0;
      wbank_r   <= 1'b0;
      busy_r    <= '0;
    end else begin
      prev_r    <= prev_nxt;
      have_r    <= have_nxt;
      in_run_r  <= in_run_nxt;
      run_cnt_r <= run_cnt_nxt;
      lit_cnt_r <= lit_cnt_nxt;
      wbank_r   <= wbank_nxt;
      busy_r    <= busy_nxt;
    end
  end

  a_run_empty_store: assert property (@(posedge clk) disable iff (!rst_n)
    in_run_r |-> (lit_cnt_r == '0))
    else $error("literal store not empty during a run");

  a_write_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !busy_r[wbank_r])
    else $error("literal write into a bank still being drained");

  a_prev_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (have_r && !in_run_r) |-> (lit_cnt_r != '0))
    else $error("previous byte outside a run but store empty");

endmodule

>>> rtl/core/rle_cmd_fifo.sv
module rle_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rle_pkg::cmd_t push_cmd,
  input  logic          pop,
  output rle_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import rle_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : PW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : PW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= NW'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= NW'(count_r - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue underflow");

  a_nonempty_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_cmd.run_en || push_cmd.lit_en))
    else $error("command with no output queued");

endmodule

>>> rtl/core/rle_back.sv
module rle_back #(
  parameter int MAX_LITERAL = 63,
  localparam int AW         = $clog2(MAX_LITERAL)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fifo_empty,
  input  rle_pkg::cmd_t       head,
  output logic                pop,
  output logic                rd_en,
  output logic [AW:0]         rd_addr,
  input  logic [7:0]          rd_data,
  output rle_pkg::bank_rel_t  rel,
  output logic                out_valid,
  input  logic                out_stall,
  output rle_pkg::out_item_t  out_data
);
  import rle_pkg::*;

  localparam int CW = $clog2(MAX_LITERAL + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUNC = 5'b00010,
    ST_RUNS = 5'b00100,
    ST_LITC = 5'b01000,
    ST_LITD = 5'b10000
  } back_st_t;

  back_st_t      st_r, st_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          adv;
  logic [CW-1:0] lit_cnt;
  logic          lit_end;
  logic          tail;

  assign adv     = !out_valid_r || !out_stall;
  assign lit_cnt = CW'(cmd_r.lit_cnt);
  assign lit_end = (idx_r == lit_cnt);

  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !adv;
    pop           = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = {cmd_r.lit_bank, idx_r[AW-1:0]};
    rel           = '0;
    tail          = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          if (head.run_en && !(head.lit_en && head.lit_first)) begin
            st_nxt = ST_RUNC;
          end else begin
            st_nxt = ST_LITC;
          end
        end
      end
      ST_RUNC: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: 8'(cmd_r.run_cnt), last_result: 1'b0, stream_done: 1'b0};
          st_nxt        = ST_RUNS;
        end
      end
      ST_RUNS: begin
        if (adv) begin
          tail          = !(cmd_r.lit_en && !cmd_r.lit_first);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: cmd_r.run_sym, last_result: tail,
                            stream_done: tail && cmd_r.done};
          st_nxt        = tail ? ST_IDLE : ST_LITC;
        end
      end
      ST_LITC: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: 8'd0 - 8'(cmd_r.lit_cnt), last_result: 1'b0,
                            stream_done: 1'b0};
          // Prefetch the first literal of the group.
          rd_en         = 1'b1;
          rd_addr       = {cmd_r.lit_bank, {AW{1'b0}}};
          idx_nxt       = CW'(1);
          st_nxt        = ST_LITD;
        end
      end
      ST_LITD: begin
        if (adv) begin
          tail          = lit_end && !(cmd_r.run_en && cmd_r.lit_first);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: rd_data, last_result: tail,
                            stream_done: tail && cmd_r.done};
          if (lit_end) begin
            rel.en   = 1'b1;
            rel.bank = cmd_r.lit_bank;
            st_nxt   = tail ? ST_IDLE : ST_RUNC;
          end else begin
            rd_en   = 1'b1;
            idx_nxt = CW'(idx_r + 1'b1);
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LITD) |-> ((idx_r != '0) && (idx_r <= lit_cnt)))
    else $error("literal index outside the group");

  a_busy_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> (cmd_r.run_en || cmd_r.lit_en))
    else $error("back end working on an empty command");

  a_lit_state: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_LITC) || (st_r == ST_LITD)) |-> (cmd_r.lit_en && (lit_cnt != '0)))
    else $error("literal output without a literal group");

endmodule

>>> rtl/core/rle_literal_run_encoder.sv
// Results of an item pass through the command queue and the back end's registered output,
// one byte per cycle while out_stall is low; the back end returns to idle between commands.
// Input takes one byte per cycle while the 4-entry command queue has room and the
// literal bank being filled is not still draining; groups of up to 63 bytes can stall it.
// Reset (rst_n low, synchronous) clears encoder state, queue and output; the literal
// store is not cleared.
module rle_literal_run_encoder #(
  parameter int MAX_RUN     = 127,
  parameter int MAX_LITERAL = 63,
  parameter int FIFO_DEPTH  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rle_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rle_pkg::out_item_t  out_data
);
  import rle_pkg::*;

  localparam int AW = $clog2(MAX_LITERAL);

  logic        fifo_full, fifo_empty;
  logic        push, pop;
  cmd_t        push_cmd, head;
  logic        wr_en, rd_en;
  logic [AW:0] wr_addr, rd_addr;
  logic [7:0]  wr_data, rd_data;
  bank_rel_t   rel;

  rle_front #(
    .MAX_RUN     (MAX_RUN),
    .MAX_LITERAL (MAX_LITERAL)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (push_cmd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rel       (rel)
  );

  rle_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  // Two banks of literals: the front end fills one while the back end drains the other.
  rle_ram #(
    .WIDTH (8),
    .DEPTH (2 << AW)
  ) u_lit_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rle_back #(
    .MAX_LITERAL (MAX_LITERAL)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> test/tb_rle_literal_run_encoder.sv
`timescale 1ns / 100ps

module tb_rle_literal_run_encoder;
  import rle_pkg::*;

  localparam int MAX_RUN      = 127;
  localparam int MAX_LITERAL  = 63;
  localparam int QUIET_LIMIT  = 4000;
  localparam int ERR_PRINT    = 20;

  // {end_of_stream, byte}
  localparam logic [8:0] DIRECTED [21] = '{
    9'h100, 9'h1FF, 9'h05A, 9'h15A, 9'h001, 9'h002, 9'h003, 9'h003, 9'h003, 9'h104,
    9'h080, 9'h080, 9'h07F, 9'h17F, 9'h011, 9'h122, 9'h000, 9'h000, 9'h0FF, 9'h0FF,
    9'h100
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  pending_bytes[$];
  out_item_t encoded_bytes[$];
  logic [7:0] step_bytes[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_in = 0;
  int unsigned bytes_checked = 0;
  int unsigned streams = 0;
  int unsigned run_pairs = 0;
  int unsigned literal_groups = 0;
  int unsigned full_runs = 0;
  int unsigned full_groups = 0;
  logic [7:0] gen_last = 8'h00;

  // Encoder state mirror
  logic [7:0] prev_sym = 8'h00;
  logic       have_prev = 1'b0;
  logic       run_open = 1'b0;
  logic [6:0] run_len = '0;
  logic [6:0] lit_len = '0;
  logic [7:0] lit_buf [MAX_LITERAL];

  rle_literal_run_encoder #(
    .MAX_RUN(MAX_RUN),
    .MAX_LITERAL(MAX_LITERAL)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function void close_run();
    step_bytes.push_back({1'b0, run_len});
    step_bytes.push_back(prev_sym);
    if (run_len >= 7'(MAX_RUN)) full_runs++;
    run_pairs++;
    run_open = 1'b0;
    run_len = '0;
  endfunction

  function void flush_group();
    if (lit_len != 0) begin
      step_bytes.push_back(8'd0 - {1'b0, lit_len});
      for (int i = 0; i < int'(lit_len) && i < MAX_LITERAL; i++)
        step_bytes.push_back(lit_buf[i]);
      literal_groups++;
      lit_len = '0;
    end
  endfunction

  function void hold_literal(input logic [7:0] sym);
    if (lit_len < 7'(MAX_LITERAL)) lit_buf[lit_len] = sym;
    lit_len = lit_len + 7'd1;
    prev_sym = sym;
    have_prev = 1'b1;
    if (lit_len >= 7'(MAX_LITERAL)) begin
      full_groups++;
      flush_group();
      // a full group never pairs with the next byte
      have_prev = 1'b0;
    end
  endfunction

  // Compute the encoded bytes caused by one raw byte and queue them.
  function void encode_byte(input in_item_t item);
    out_item_t res;
    step_bytes.delete();
    if (!have_prev) begin
      hold_literal(item.in_byte);
    end else if (run_open) begin
      if (item.in_byte == prev_sym) begin
        run_len = run_len + 7'd1;
        if (run_len >= 7'(MAX_RUN)) begin
          close_run();
          have_prev = 1'b0;
        end
      end else begin
        close_run();
        hold_literal(item.in_byte);
      end
    end else if (item.in_byte == prev_sym) begin
      // take the repeated byte back out of the group and open a run of two
      if (lit_len > 0) lit_len = lit_len - 7'd1;
      flush_group();
      run_open = 1'b1;
      run_len = 7'd2;
      if (run_len >= 7'(MAX_RUN)) begin
        close_run();
        have_prev = 1'b0;
      end
    end else begin
      hold_literal(item.in_byte);
    end
    if (item.end_of_stream) begin
      if (run_open) close_run();
      else flush_group();
      prev_sym = 8'h00;
      have_prev = 1'b0;
      run_open = 1'b0;
      run_len = '0;
      lit_len = '0;
      streams++;
    end
    foreach (step_bytes[i]) begin
      res.out_byte = step_bytes[i];
      res.last_result = (i == step_bytes.size() - 1);
      res.stream_done = item.end_of_stream && (i == step_bytes.size() - 1);
      encoded_bytes.push_back(res);
    end
  endfunction

  // Driver: hold a stalled transaction, otherwise load the next byte or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on input transactions, check on output transactions.
  always @(posedge clk) begin
    out_item_t want;
    logic took_in;
    logic took_out;
    if (!rst_n) begin
      out_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      took_in = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (took_in) begin
        bytes_in++;
        encode_byte(in_data);
      end
      if (took_out) begin
        bytes_checked++;
        if (encoded_bytes.size() == 0) begin
          errors++;
          if (errors <= ERR_PRINT)
            $display("%0t: unexpected output: expected none, actual byte %h last %b done %b",
                     $time, out_data.out_byte, out_data.last_result, out_data.stream_done);
        end else begin
          want = encoded_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.last_result !== want.last_result ||
              out_data.stream_done !== want.stream_done) begin
            errors++;
            if (errors <= ERR_PRINT)
              $display("%0t: mismatch: expected byte %h last %b done %b, actual byte %h last %b done %b",
                       $time, want.out_byte, want.last_result, want.stream_done,
                       out_data.out_byte, out_data.last_result, out_data.stream_done);
          end
        end
      end
      quiet_cycles <= (took_in || took_out) ? 0 : quiet_cycles + 1;
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic logic [7:0] pick_sym();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2, 3: return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] sym, input logic eos);
    in_item_t item;
    item.in_byte = sym;
    item.end_of_stream = eos;
    pending_bytes.push_back(item);
    gen_last = sym;
  endtask

  task automatic queue_random_traffic(input int target);
    int made;
    int len;
    int kind;
    logic [7:0] sym;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        len = $urandom_range(2, 6);
        sym = pick_sym();
        repeat (len) queue_byte(sym, 1'b0);
      end else if (kind < 8) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          do sym = pick_sym(); while (sym == gen_last);
          queue_byte(sym, 1'b0);
        end
      end else begin
        // noise from a tiny alphabet, with stray stream ends
        len = $urandom_range(1, 6);
        repeat (len) queue_byte(8'($urandom_range(0, 2)), $urandom_range(0, 7) == 0);
      end
      made += len;
      if ($urandom_range(0, 4) == 0)
        pending_bytes[pending_bytes.size() - 1].end_of_stream = 1'b1;
    end
    pending_bytes[pending_bytes.size() - 1].end_of_stream = 1'b1;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || encoded_bytes.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    do @(negedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] sym;
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no idling: directed cases, then a little random traffic
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (DIRECTED[i]) queue_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    queue_random_traffic(8);
    wait_drained();

    // sender mostly idle, with a run that reaches the limit
    send_idle_pct = 87;
    recv_stall_pct = 0;
    sym = pick_sym();
    len = $urandom_range(MAX_RUN, MAX_RUN + 3);
    repeat (len) queue_byte(sym, 1'b0);
    pending_bytes[pending_bytes.size() - 1].end_of_stream = 1'b1;
    wait_drained();

    // receiver mostly stalling, with a literal group that fills the store
    send_idle_pct = 0;
    recv_stall_pct = 87;
    repeat (MAX_LITERAL) begin
      do sym = pick_sym(); while (sym == gen_last);
      queue_byte(sym, 1'b0);
    end
    // repeat the last byte of the full group: fresh literal, then a run
    queue_byte(gen_last, 1'b0);
    queue_byte(gen_last, 1'b1);
    wait_drained();

    send_idle_pct = 35;
    recv_stall_pct = 35;
    queue_random_traffic(8);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (40) @(negedge clk);

    $display("Encoded %0d raw bytes in %0d streams; checked %0d output bytes.",
             bytes_in, streams, bytes_checked);
    $display("Covered %0d run pairs (%0d at the run limit) and %0d literal groups (%0d full).",
             run_pairs, full_runs, literal_groups, full_groups);
    if (errors == 0 && encoded_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
